[rtl/core/spdrr_pkg.sv]
// ----------------------------------------------------------------------------
// spdrr_pkg
// Shared widths, operation and register codes, and the pick result type
// for the strict priority / DRR slot scheduler.
// ----------------------------------------------------------------------------
package spdrr_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int MASK_W      = 8;
    localparam int BYTES_W     = 16;
    localparam int QUANTUM_W   = 16;
    localparam int COUNT_W     = 64;
    localparam int DEFICIT_W   = 18;
    localparam int OP_W        = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic signed [DEFICIT_W-1:0] DEFICIT_MIN = 18'sh20000;

    typedef enum logic [OP_W-1:0] {
        OP_SELECT     = 3'd0,
        OP_PEEK       = 3'd1,
        OP_DEQUEUE    = 3'd2,
        OP_ENQUEUE    = 3'd3,
        OP_READ_COUNT = 3'd4
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STRICT_MASK  = 2'd0,
        CFG_QUANTUM_LOW  = 2'd1,
        CFG_QUANTUM_HIGH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                  found;
        logic                  drr;
        logic [SLOT_IDX_W-1:0] slot;
    } pick_t;

endpackage

[rtl/core/spdrr_pick.sv]
// ----------------------------------------------------------------------------
// spdrr_pick
// Slot arbiter: lowest eligible strict slot, else first eligible
// non-strict slot walking from the round cursor.
// ----------------------------------------------------------------------------
module spdrr_pick
    import spdrr_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int SLOT_W = $clog2(SLOTS)
) (
    input  logic [SLOTS-1:0]  eligible,
    input  logic [SLOTS-1:0]  strict_vec,
    input  logic [SLOT_W-1:0] cursor,
    output pick_t             pick
);

    logic [SLOTS-1:0]      strict_elig;
    logic [SLOTS-1:0]      drr_elig;
    logic                  strict_hit;
    logic [SLOT_IDX_W-1:0] strict_slot;
    logic                  drr_hit;
    logic [SLOT_IDX_W-1:0] drr_slot;

    assign strict_elig = eligible & strict_vec;
    assign drr_elig    = eligible & ~strict_vec;

    always_comb begin
        strict_hit  = 1'b0;
        strict_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (strict_elig[i]) begin
                strict_hit  = 1'b1;
                strict_slot = SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        logic [SLOT_W:0] pos;
        drr_hit  = 1'b0;
        drr_slot = '0;
        for (int t = SLOTS - 1; t >= 0; t--) begin
            pos = {1'b0, cursor} + (SLOT_W + 1)'(t);
            if (pos >= (SLOT_W + 1)'(SLOTS)) begin
                pos = pos - (SLOT_W + 1)'(SLOTS);
            end
            if (drr_elig[pos[SLOT_W-1:0]]) begin
                drr_hit  = 1'b1;
                drr_slot = SLOT_IDX_W'(pos[SLOT_W-1:0]);
            end
        end
    end

    always_comb begin
        pick = '0;
        if (strict_hit) begin
            pick.found = 1'b1;
            pick.slot  = strict_slot;
        end else if (drr_hit) begin
            pick.found = 1'b1;
            pick.drr   = 1'b1;
            pick.slot  = drr_slot;
        end
    end

endmodule

[rtl/core/strict_priority_drr_scheduler_top.sv]
// ----------------------------------------------------------------------------
// strict_priority_drr_scheduler_top
// Hybrid strict priority / deficit round robin slot scheduler with
// per-slot byte counters.
// ----------------------------------------------------------------------------
// Takes one request beat per clock while the result side is not stalled, and
// returns exactly one result beat per request: the request is held in the
// input register, then the pick, deficit update and counter update resolve
// combinationally from it into the result register. That pick and
// deficit/cursor update path sets the rate of one request per clock.
// A full result register back-pressures through the input register, so up to
// two requests are held while m_ready is low. Configuration writes through
// cfg_wr_en / cfg_index / cfg_wdata take effect at once and are meant for
// idle periods only.
module strict_priority_drr_scheduler_top
    import spdrr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [MASK_W-1:0]     s_backlog_mask,
    input  logic [MASK_W-1:0]     s_gate_mask,
    input  logic [SLOT_IDX_W-1:0] s_slot_index,
    input  logic [BYTES_W-1:0]    s_packet_bytes,
    input  logic                  s_still_backlogged,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_chosen_valid,
    output logic [SLOT_IDX_W-1:0] m_chosen_slot,
    output logic [COUNT_W-1:0]    m_enqueued_byte_count,
    output logic [COUNT_W-1:0]    m_dequeued_byte_count
);

    localparam int SLOT_W = $clog2(SLOTS);

    // configuration
    logic [MASK_W-1:0]     strict_mask_reg;
    logic [CFG_DATA_W-1:0] quantum_low_reg;
    logic [CFG_DATA_W-1:0] quantum_high_reg;

    // input stage
    logic                  in_valid_reg;
    logic [OP_W-1:0]       op_reg;
    logic [MASK_W-1:0]     backlog_reg;
    logic [MASK_W-1:0]     gate_reg;
    logic [SLOT_IDX_W-1:0] slot_reg;
    logic [BYTES_W-1:0]    bytes_reg;
    logic                  more_reg;

    // scheduler state
    logic signed [DEFICIT_W-1:0] deficit_reg [SLOTS];
    logic [SLOT_W-1:0]           cursor_reg;
    logic [COUNT_W-1:0]          cnt_in_reg  [SLOTS];
    logic [COUNT_W-1:0]          cnt_out_reg [SLOTS];

    // result stage
    logic                  out_valid_reg;
    logic                  chosen_valid_reg;
    logic [SLOT_IDX_W-1:0] chosen_slot_reg;
    logic [COUNT_W-1:0]    enq_count_reg;
    logic [COUNT_W-1:0]    deq_count_reg;

    logic                  advance;
    logic                  fire;
    logic [SLOTS-1:0]      eligible;
    logic [SLOTS-1:0]      strict_vec;
    pick_t                 pick;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot_sel;
    logic [SLOT_W-1:0]     def_idx;
    logic [SLOT_IDX_W-1:0] def_idx_ext;
    logic signed [DEFICIT_W-1:0] def_cur;
    logic [CFG_DATA_W-1:0] quantum_word;
    logic [QUANTUM_W-1:0]  quantum;
    logic signed [DEFICIT_W:0]   def_credit_wide;
    logic signed [DEFICIT_W:0]   def_charge_wide;
    logic signed [DEFICIT_W-1:0] def_credited;
    logic signed [DEFICIT_W-1:0] def_charged;
    logic [SLOT_W-1:0]     slot_after;

    logic                        def_we;
    logic signed [DEFICIT_W-1:0] deficit_next;
    logic [SLOT_W-1:0]           cursor_next;
    logic                        cnt_in_we;
    logic                        cnt_out_we;
    logic [COUNT_W-1:0]          cnt_in_next;
    logic [COUNT_W-1:0]          cnt_out_next;
    logic                        chosen_valid_next;
    logic [SLOT_IDX_W-1:0]       chosen_slot_next;
    logic [COUNT_W-1:0]          enq_count_next;
    logic [COUNT_W-1:0]          deq_count_next;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign eligible   = backlog_reg[SLOTS-1:0] & gate_reg[SLOTS-1:0];
    assign strict_vec = strict_mask_reg[SLOTS-1:0];

    spdrr_pick #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_pick (
        .eligible   (eligible),
        .strict_vec (strict_vec),
        .cursor     (cursor_reg),
        .pick       (pick)
    );

    assign slot_ok  = ({1'b0, slot_reg} < (SLOT_IDX_W + 1)'(SLOTS));
    assign slot_sel = slot_reg[SLOT_W-1:0];

    assign def_idx     = (op_reg == OP_SELECT) ? pick.slot[SLOT_W-1:0] : slot_sel;
    assign def_idx_ext = SLOT_IDX_W'(def_idx);
    assign def_cur     = deficit_reg[def_idx];

    assign quantum_word = def_idx_ext[2] ? quantum_high_reg : quantum_low_reg;
    assign quantum      = QUANTUM_W'(quantum_word >> {def_idx_ext[1:0], 4'b0000});

    assign def_credit_wide = {def_cur[DEFICIT_W-1], def_cur}
                           + $signed({3'b000, quantum});
    assign def_credited    = (def_cur <= 0) ? def_credit_wide[DEFICIT_W-1:0] : def_cur;

    assign def_charge_wide = {def_cur[DEFICIT_W-1], def_cur}
                           - $signed({3'b000, bytes_reg});
    assign def_charged     = (def_charge_wide < $signed({DEFICIT_MIN[DEFICIT_W-1], DEFICIT_MIN}))
                           ? DEFICIT_MIN : def_charge_wide[DEFICIT_W-1:0];

    assign slot_after = (slot_sel == SLOT_W'(SLOTS - 1)) ? '0 : slot_sel + 1'b1;

    assign cnt_in_next  = cnt_in_reg[slot_sel]  + COUNT_W'(bytes_reg);
    assign cnt_out_next = cnt_out_reg[slot_sel] + COUNT_W'(bytes_reg);

    always_comb begin
        def_we            = 1'b0;
        deficit_next      = def_cur;
        cursor_next       = cursor_reg;
        cnt_in_we         = 1'b0;
        cnt_out_we        = 1'b0;
        chosen_valid_next = 1'b0;
        chosen_slot_next  = '0;
        enq_count_next    = '0;
        deq_count_next    = '0;
        case (op_t'(op_reg))
            OP_SELECT: begin
                if (pick.found) begin
                    chosen_valid_next = 1'b1;
                    chosen_slot_next  = pick.slot;
                end
                if (pick.drr) begin
                    def_we       = 1'b1;
                    deficit_next = def_credited;
                    cursor_next  = pick.slot[SLOT_W-1:0];
                end
            end
            OP_PEEK: begin
                if (pick.found) begin
                    chosen_valid_next = 1'b1;
                    chosen_slot_next  = pick.slot;
                end
            end
            OP_DEQUEUE: begin
                cnt_out_we = slot_ok;
                if (slot_ok && !strict_vec[slot_sel]) begin
                    def_we = 1'b1;
                    if (!more_reg) begin
                        deficit_next = '0;
                    end else begin
                        deficit_next = def_charged;
                        if (def_charged <= 0) begin
                            cursor_next = slot_after;
                        end
                    end
                end
            end
            OP_ENQUEUE: begin
                cnt_in_we = slot_ok;
            end
            OP_READ_COUNT: begin
                if (slot_ok) begin
                    enq_count_next = cnt_in_reg[slot_sel];
                    deq_count_next = cnt_out_reg[slot_sel];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_mask_reg  <= '0;
            quantum_low_reg  <= '0;
            quantum_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_STRICT_MASK:  strict_mask_reg  <= cfg_wdata[MASK_W-1:0];
                CFG_QUANTUM_LOW:  quantum_low_reg  <= cfg_wdata;
                CFG_QUANTUM_HIGH: quantum_high_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= s_operation;
            backlog_reg <= s_backlog_mask;
            gate_reg    <= s_gate_mask;
            slot_reg    <= s_slot_index;
            bytes_reg   <= s_packet_bytes;
            more_reg    <= s_still_backlogged;
        end
        if (fire) begin
            chosen_valid_reg <= chosen_valid_next;
            chosen_slot_reg  <= chosen_slot_next;
            enq_count_reg    <= enq_count_next;
            deq_count_reg    <= deq_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                deficit_reg[i] <= '0;
                cnt_in_reg[i]  <= '0;
                cnt_out_reg[i] <= '0;
            end
        end else if (fire) begin
            cursor_reg <= cursor_next;
            if (def_we) begin
                deficit_reg[def_idx] <= deficit_next;
            end
            if (cnt_in_we) begin
                cnt_in_reg[slot_sel] <= cnt_in_next;
            end
            if (cnt_out_we) begin
                cnt_out_reg[slot_sel] <= cnt_out_next;
            end
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_chosen_valid        = chosen_valid_reg;
    assign m_chosen_slot         = chosen_slot_reg;
    assign m_enqueued_byte_count = enq_count_reg;
    assign m_dequeued_byte_count = deq_count_reg;

endmodule

[rtl/core/spdrr_checker.sv]
// ----------------------------------------------------------------------------
// spdrr_checker
// Port-level checks for the strict priority / DRR slot scheduler.
// ----------------------------------------------------------------------------
module spdrr_checker
    import spdrr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_ready,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_chosen_valid,
    input  logic [SLOT_IDX_W-1:0] m_chosen_slot,
    input  logic [COUNT_W-1:0]    m_enqueued_byte_count,
    input  logic [COUNT_W-1:0]    m_dequeued_byte_count
);

    // hold a stalled result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_valid)
            && $stable(m_chosen_slot) && $stable(m_enqueued_byte_count)
            && $stable(m_dequeued_byte_count))
        else $error("result beat changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with result side empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_chosen_valid |-> m_chosen_slot == '0)
        else $error("slot reported without a pick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chosen_valid |-> {1'b0, m_chosen_slot} < (SLOT_IDX_W + 1)'(SLOTS))
        else $error("picked slot out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_enqueued_byte_count != '0 || m_dequeued_byte_count != '0)
            |-> !m_chosen_valid)
        else $error("counter read beat also carries a pick");

endmodule

bind strict_priority_drr_scheduler_top spdrr_checker #(
    .SLOTS (SLOTS)
) u_spdrr_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_ready               (s_ready),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_chosen_valid        (m_chosen_valid),
    .m_chosen_slot         (m_chosen_slot),
    .m_enqueued_byte_count (m_enqueued_byte_count),
    .m_dequeued_byte_count (m_dequeued_byte_count)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the strict priority / DRR slot scheduler. Requests
// go in over a valid/ready channel. Each one is run through a bit-accurate
// scheduler model held in a small scoreboard class. Every result beat is
// checked field by field against the oldest prediction. A short directed
// sequence comes first. Random phases follow, with different register
// settings and sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;
    import spdrr_pkg::*;

    localparam int QUANTA_PER_WORD = CFG_DATA_W / QUANTUM_W;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 250;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [MASK_W-1:0]     backlog;
        logic [MASK_W-1:0]     gate;
        logic [SLOT_IDX_W-1:0] slot;
        logic [BYTES_W-1:0]    bytes;
        logic                  more;
    } sched_req_t;

    typedef struct packed {
        logic                  chosen_valid;
        logic [SLOT_IDX_W-1:0] chosen_slot;
        logic [COUNT_W-1:0]    enq;
        logic [COUNT_W-1:0]    deq;
    } sched_result_t;

    class sched_scoreboard;
        logic [MASK_W-1:0]           strict_bits;
        logic [QUANTUM_W-1:0]        quantum   [SLOTS_DEF];
        logic signed [DEFICIT_W-1:0] deficit   [SLOTS_DEF];
        logic [SLOT_IDX_W-1:0]       cursor;
        logic [COUNT_W-1:0]          bytes_in  [SLOTS_DEF];
        logic [COUNT_W-1:0]          bytes_out [SLOTS_DEF];
        sched_result_t               awaited[$];
        logic [SLOT_IDX_W-1:0]       last_pick;
        bit                          last_pick_found;
        int                          errors;

        function new();
            strict_bits     = '0;
            cursor          = '0;
            last_pick       = '0;
            last_pick_found = 1'b0;
            errors          = 0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                quantum[i]   = '0;
                deficit[i]   = '0;
                bytes_in[i]  = '0;
                bytes_out[i] = '0;
            end
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STRICT_MASK: strict_bits = data[MASK_W-1:0];
                CFG_QUANTUM_LOW: begin
                    for (int k = 0; k < QUANTA_PER_WORD; k++)
                        quantum[k] = data[QUANTUM_W*k +: QUANTUM_W];
                end
                CFG_QUANTUM_HIGH: begin
                    for (int k = 0; k < QUANTA_PER_WORD; k++)
                        quantum[QUANTA_PER_WORD+k] = data[QUANTUM_W*k +: QUANTUM_W];
                end
                default: ;
            endcase
        endfunction

        function int pick(logic [MASK_W-1:0] elig);
            int s;
            for (int i = 0; i < SLOTS_DEF; i++)
                if (strict_bits[i] && elig[i])
                    return i;
            for (int t = 0; t < SLOTS_DEF; t++) begin
                s = (int'(cursor) + t) % SLOTS_DEF;
                if (!strict_bits[s] && elig[s])
                    return s;
            end
            return -1;
        endfunction

        function void note_request(sched_req_t r);
            sched_result_t e;
            int            c;
            int            d;
            e = '0;
            case (r.op)
                OP_SELECT, OP_PEEK: begin
                    c = pick(r.backlog & r.gate);
                    if (c >= 0) begin
                        e.chosen_valid = 1'b1;
                        e.chosen_slot  = c[SLOT_IDX_W-1:0];
                        if (r.op == OP_SELECT && !strict_bits[c]) begin
                            if (deficit[c] <= 0) begin
                                d          = int'(deficit[c]) + int'(quantum[c]);
                                deficit[c] = d[DEFICIT_W-1:0];
                            end
                            cursor = c[SLOT_IDX_W-1:0];
                        end
                    end
                    if (r.op == OP_SELECT) begin
                        last_pick       = e.chosen_slot;
                        last_pick_found = e.chosen_valid;
                    end
                end
                OP_DEQUEUE: begin
                    bytes_out[r.slot] = bytes_out[r.slot] + r.bytes;
                    if (!strict_bits[r.slot]) begin
                        d = int'(deficit[r.slot]) - int'(r.bytes);
                        if (d < int'(DEFICIT_MIN))
                            d = int'(DEFICIT_MIN);
                        deficit[r.slot] = d[DEFICIT_W-1:0];
                        if (!r.more)
                            deficit[r.slot] = '0;
                        else if (deficit[r.slot] <= 0)
                            cursor = r.slot + 1'b1;
                    end
                end
                OP_ENQUEUE: bytes_in[r.slot] = bytes_in[r.slot] + r.bytes;
                OP_READ_COUNT: begin
                    e.enq = bytes_in[r.slot];
                    e.deq = bytes_out[r.slot];
                end
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        function void compare(string what, logic [COUNT_W-1:0] exp_v,
                              logic [COUNT_W-1:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s mismatch, expected %0h, got %0h",
                             $time, what, exp_v, act_v);
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t e;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display("%0t: result beat with nothing outstanding, expected none, got %h",
                             $time, got);
                return;
            end
            e = awaited.pop_front();
            compare("chosen_valid", e.chosen_valid, got.chosen_valid);
            compare("chosen_slot", e.chosen_slot, got.chosen_slot);
            compare("enqueued_byte_count", e.enq, got.enq);
            compare("dequeued_byte_count", e.deq, got.deq);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation;
    logic [MASK_W-1:0]     s_backlog_mask;
    logic [MASK_W-1:0]     s_gate_mask;
    logic [SLOT_IDX_W-1:0] s_slot_index;
    logic [BYTES_W-1:0]    s_packet_bytes;
    logic                  s_still_backlogged;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_chosen_valid;
    logic [SLOT_IDX_W-1:0] m_chosen_slot;
    logic [COUNT_W-1:0]    m_enqueued_byte_count;
    logic [COUNT_W-1:0]    m_dequeued_byte_count;

    sched_scoreboard sb = new();
    int              sender_idle_pct = 0;
    int              recv_stall_pct  = 0;
    int              burst_left      = 0;

    strict_priority_drr_scheduler_top DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_operation           (s_operation),
        .s_backlog_mask        (s_backlog_mask),
        .s_gate_mask           (s_gate_mask),
        .s_slot_index          (s_slot_index),
        .s_packet_bytes        (s_packet_bytes),
        .s_still_backlogged    (s_still_backlogged),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_chosen_valid        (m_chosen_valid),
        .m_chosen_slot         (m_chosen_slot),
        .m_enqueued_byte_count (m_enqueued_byte_count),
        .m_dequeued_byte_count (m_dequeued_byte_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic sched_req_t make_request(logic [OP_W-1:0] op,
                                                logic [MASK_W-1:0] backlog,
                                                logic [MASK_W-1:0] gate,
                                                logic [SLOT_IDX_W-1:0] slot,
                                                logic [BYTES_W-1:0] bytes,
                                                logic more);
        sched_req_t r;
        r.op      = op;
        r.backlog = backlog;
        r.gate    = gate;
        r.slot    = slot;
        r.bytes   = bytes;
        r.more    = more;
        return r;
    endfunction

    function automatic sched_req_t random_request();
        sched_req_t r;
        int         w;
        w = $urandom_range(99);
        if (w < 30)
            r.op = OP_SELECT;
        else if (w < 40)
            r.op = OP_PEEK;
        else if (w < 65)
            r.op = OP_DEQUEUE;
        else if (w < 85)
            r.op = OP_ENQUEUE;
        else if (w < 95)
            r.op = OP_READ_COUNT;
        else
            r.op = OP_W'($urandom_range(2**OP_W - 1, int'(OP_READ_COUNT) + 1));
        case ($urandom_range(3))
            0: begin
                r.backlog = MASK_W'($urandom);
                r.gate    = MASK_W'($urandom);
            end
            1: begin
                r.backlog = '1;
                r.gate    = '1;
            end
            2: begin
                r.backlog = MASK_W'($urandom);
                r.gate    = '1;
            end
            default: begin
                r.backlog = MASK_W'($urandom | $urandom);
                r.gate    = MASK_W'($urandom | $urandom);
            end
        endcase
        r.slot = SLOT_IDX_W'($urandom);
        if (r.op == OP_DEQUEUE && sb.last_pick_found && $urandom_range(3) != 0)
            r.slot = sb.last_pick;
        case ($urandom_range(9))
            0:       r.bytes = '0;
            1:       r.bytes = '1;
            2, 3:    r.bytes = BYTES_W'($urandom);
            default: r.bytes = BYTES_W'($urandom_range(1500, 40));
        endcase
        r.more = ($urandom_range(9) < 7);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] small_quanta();
        logic [CFG_DATA_W-1:0] w;
        for (int k = 0; k < QUANTA_PER_WORD; k++)
            w[QUANTUM_W*k +: QUANTUM_W] = QUANTUM_W'($urandom_range(3000));
        return w;
    endfunction

    task automatic send_request(sched_req_t r);
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(39) == 0)
            burst_left = $urandom_range(30, 10);
        else
            while ($urandom_range(99) < sender_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid            <= 1'b1;
        s_operation        <= r.op;
        s_backlog_mask     <= r.backlog;
        s_gate_mask        <= r.gate;
        s_slot_index       <= r.slot;
        s_packet_bytes     <= r.bytes;
        s_still_backlogged <= r.more;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(logic [MASK_W-1:0] strict_v, logic [CFG_DATA_W-1:0] q_low,
                                logic [CFG_DATA_W-1:0] q_high);
        write_cfg(CFG_STRICT_MASK, {{(CFG_DATA_W-MASK_W){1'b0}}, strict_v});
        write_cfg(CFG_QUANTUM_LOW, q_low);
        write_cfg(CFG_QUANTUM_HIGH, q_high);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure_phase(int p);
        case (p)
            0:       program_regs('0, '1, '1);
            1:       program_regs('1, {$urandom, $urandom}, {$urandom, $urandom});
            2:       program_regs(MASK_W'($urandom), small_quanta(), small_quanta());
            3:       program_regs('0, '0, '0);
            4:       program_regs(MASK_W'($urandom), {$urandom, $urandom},
                                  {$urandom, $urandom});
            5:       program_regs(8'h81, small_quanta(), small_quanta());
            6:       program_regs('0, small_quanta(), small_quanta());
            default: program_regs(MASK_W'($urandom), {$urandom, $urandom}, '0);
        endcase
        case (p % 4)
            0: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            1: begin
                sender_idle_pct = 86;
                recv_stall_pct  = 0;
            end
            2: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 86;
            end
            default: begin
                sender_idle_pct = 32;
                recv_stall_pct  = 32;
            end
        endcase
    endtask

    initial begin
        sched_result_t got;
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.chosen_valid = m_chosen_valid;
                got.chosen_slot  = m_chosen_slot;
                got.enq          = m_enqueued_byte_count;
                got.deq          = m_dequeued_byte_count;
                sb.check_result(got);
            end
        end
    end

    initial begin
        aresetn            <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= CFG_STRICT_MASK;
        cfg_wdata          <= '0;
        s_valid            <= 1'b0;
        s_operation        <= OP_SELECT;
        s_backlog_mask     <= '0;
        s_gate_mask        <= '0;
        s_slot_index       <= '0;
        s_packet_bytes     <= '0;
        s_still_backlogged <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // slots 2 and 5 strict, slot 1 zero quantum, slot 2 strict with a quantum
        program_regs(8'h24, {16'd1000, 16'd700, 16'd0, 16'd300},
                     {16'd64, 16'd1500, 16'd200, 16'hFFFF});
        send_request(make_request(OP_SELECT, 8'h00, 8'h00, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_PEEK, 8'hFF, 8'hFF, 3'd7, 16'hFFFF, 1'b1));
        send_request(make_request(OP_SELECT, 8'hFF, 8'hDB, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_PEEK, 8'h02, 8'hFF, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_SELECT, 8'h02, 8'hFF, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00, 3'd1, 16'hFFFF, 1'b1));
        send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00, 3'd1, 16'hFFFF, 1'b1));
        send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00, 3'd1, 16'hFFFF, 1'b1));
        send_request(make_request(OP_SELECT, 8'h02, 8'h02, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00, 3'd1, 16'd10, 1'b0));
        send_request(make_request(OP_DEQUEUE, 8'hFF, 8'hFF, 3'd2, 16'd1500, 1'b1));
        send_request(make_request(OP_DEQUEUE, 8'h00, 8'h00, 3'd6, 16'd1000, 1'b1));
        send_request(make_request(OP_SELECT, 8'h80, 8'h80, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_ENQUEUE, 8'h00, 8'h00, 3'd7, 16'hFFFF, 1'b0));
        send_request(make_request(OP_ENQUEUE, 8'h00, 8'h00, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_ENQUEUE, 8'h00, 8'h00, 3'd7, 16'd1, 1'b0));
        send_request(make_request(OP_READ_COUNT, 8'h00, 8'h00, 3'd7, 16'd0, 1'b0));
        send_request(make_request(OP_READ_COUNT, 8'hFF, 8'hFF, 3'd1, 16'hFFFF, 1'b1));
        send_request(make_request(OP_READ_COUNT, 8'h00, 8'h00, 3'd0, 16'd0, 1'b0));
        for (int o = int'(OP_READ_COUNT) + 1; o < 2**OP_W; o++) begin
            send_request(make_request(OP_W'(o), 8'hFF, 8'hFF, 3'd7, 16'hFFFF, 1'b1));
            send_request(make_request(OP_W'(o), 8'h00, 8'h00, 3'd0, 16'd0, 1'b0));
        end
        send_request(make_request(OP_SELECT, 8'hFF, 8'hFF, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_PEEK, 8'h00, 8'hFF, 3'd0, 16'd0, 1'b0));
        send_request(make_request(OP_SELECT, 8'hFB, 8'hFB, 3'd0, 16'd0, 1'b0));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            configure_phase(p);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off until the pipe is empty once per phase
                if (n == PHASE_ITEMS / 2)
                    drain();
                send_request(random_request());
            end
            drain();
        end

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
